// ===== sv/sfcb_pkg.sv =====
// Shared types, sizes and codes for the serial flow-control buffer.
package sfcb_pkg;

  // Queue sizes and the widths that follow from them
  localparam int RX_DEPTH  = 256;
  localparam int TX_DEPTH  = 512;
  localparam int RX_AW     = $clog2(RX_DEPTH);
  localparam int RX_CW     = $clog2(RX_DEPTH + 1);
  localparam int TX_AW     = $clog2(TX_DEPTH);
  localparam int TX_CW     = $clog2(TX_DEPTH + 1);
  localparam int RX_PW     = (RX_CW > 8) ? RX_CW : 8;
  localparam int RX_FILL_W = 9;
  localparam int TX_FILL_W = 10;

  // Flow-control characters and idle counter ceiling
  localparam logic [7:0]  XON_BYTE  = 8'd17;
  localparam logic [7:0]  XOFF_BYTE = 8'd19;
  localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_POLL  = 3'd1,
    MODE_PUSH  = 3'd2,
    MODE_POP   = 3'd3,
    MODE_PEEK  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    FLOW_NONE = 2'd0,
    FLOW_RTS  = 2'd1,
    FLOW_XON  = 2'd2
  } flow_mode_t;

  typedef enum logic [1:0] {
    CFG_FLOW_MODE  = 2'd0,
    CFG_RX_RESERVE = 2'd1,
    CFG_IDLE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EXIT_NO_ACT   = 2'd0,
    EXIT_FULL     = 2'd1,
    EXIT_OVERFLOW = 2'd2
  } exit_code_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_XCHG  = 2'd1,
    PH_DRAIN = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       cts;
    logic       tx_ready;
    logic [7:0] host_byte;
    logic [7:0] peek_offset;
  } sfcb_in_t;

  typedef struct packed {
    logic                 tx_valid;
    logic [7:0]           tx_byte;
    logic                 flow_valid;
    logic [7:0]           flow_byte;
    logic                 rts;
    logic [7:0]           read_byte;
    logic                 push_ok;
    logic                 done_res;
    logic [1:0]           exit_code;
    logic                 active;
    logic [RX_FILL_W-1:0] rx_fill;
    logic [TX_FILL_W-1:0] tx_fill;
  } sfcb_out_t;

  // Result beat waiting for its queue read data
  typedef struct packed {
    sfcb_out_t res;
    logic      use_tx;
    logic      use_rx;
  } sfcb_stage_t;

endpackage

// ===== sv/sfcb_ram.sv =====
// Simple dual-port byte store with registered read data.
module sfcb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: hold the last read until the next one
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/serial_flow_control_buffer.sv =====
// Top level: serial link buffer with receive/transmit rings and flow control.
//
//  channel | ports                               | carries
//  --------+-------------------------------------+----------------------------------
//  input   | in_valid, in_ready, in_data         | start, poll, push, pop, peek item
//  result  | out_valid, out_ready, out_data      | one result beat per item
//  config  | cfg_valid, cfg_ready, cfg_index,    | flow_mode, rx_reserve, idle_limit
//          | cfg_data                            |
//
// One item is taken per cycle while in_ready is high, which a stalled output can drop.
// All state is updated at the accepting edge, where the queue read is also issued;
// the registered read data of the ring store is merged in on the way to out_data.
// Reset is synchronous and needs no clearing pass: ring contents are only read
// where written. A stalled result holds in the output register while one more
// item may be taken into the middle stage.
module serial_flow_control_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfcb_pkg::sfcb_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfcb_pkg::sfcb_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sfcb_pkg::*;

  // Configuration
  logic [1:0]  flow_mode_r;
  logic [7:0]  rx_reserve_r;
  logic [15:0] idle_limit_r;

  // Queue and link state
  logic [RX_AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [RX_CW-1:0] rx_count_r, rx_count_nxt;
  logic [TX_AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [TX_CW-1:0] tx_count_r, tx_count_nxt;
  logic             send_allowed_r, send_allowed_nxt;
  logic             announced_r, announced_nxt;
  logic             rts_r, rts_nxt;
  phase_t           phase_r, phase_nxt;
  logic [15:0]      idle_count_r, idle_count_nxt;

  // Pipeline
  logic        a_valid_r, a_valid_nxt, b_valid_r, b_valid_nxt;
  sfcb_stage_t a_r, a_nxt;
  sfcb_out_t   b_r, b_in;
  logic        in_fire, b_load;

  // Ring store ports
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [RX_AW-1:0] rx_raddr;
  logic [TX_AW-1:0] tx_raddr;
  logic [7:0]       rx_rdata, tx_rdata;

  // Item working values
  logic [15:0]    idle_v;
  logic [RX_CW-1:0] rxc_v;
  logic           can_send;
  logic           req_on, req_off;
  logic [RX_PW:0] peek_sum;

  function automatic logic rx_mark(input logic [RX_CW-1:0] cnt, input logic [7:0] rsv);
    logic [RX_PW:0] sum;
    sum = (RX_PW+1)'(cnt) + (RX_PW+1)'(rsv);
    return sum >= (RX_PW+1)'(RX_DEPTH);
  endfunction

  sfcb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail_r),
    .wdata (in_data.rx_byte),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  sfcb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail_r),
    .wdata (in_data.host_byte),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // Handshakes
  assign cfg_ready = 1'b1;
  assign b_load    = a_valid_r && (!b_valid_r || out_ready);
  assign in_ready  = !a_valid_r || b_load;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = b_valid_r;
  assign out_data  = b_r;

  // Work out the item: state update, queue access and result fields
  always_comb begin
    rx_head_nxt      = rx_head_r;
    rx_tail_nxt      = rx_tail_r;
    rx_count_nxt     = rx_count_r;
    tx_head_nxt      = tx_head_r;
    tx_tail_nxt      = tx_tail_r;
    tx_count_nxt     = tx_count_r;
    send_allowed_nxt = send_allowed_r;
    announced_nxt    = announced_r;
    rts_nxt          = rts_r;
    phase_nxt        = phase_r;
    idle_v           = idle_count_r;
    rxc_v            = rx_count_r;
    can_send         = 1'b0;
    req_on           = 1'b0;
    req_off          = 1'b0;
    rx_we            = 1'b0;
    rx_re            = 1'b0;
    tx_we            = 1'b0;
    tx_re            = 1'b0;
    rx_raddr         = rx_head_r;
    tx_raddr         = tx_head_r;
    peek_sum         = (RX_PW+1)'(rx_head_r) + (RX_PW+1)'(in_data.peek_offset);
    a_nxt            = '0;

    if (in_fire) begin
      unique case (in_data.mode)
        MODE_START: begin
          if (phase_r == PH_IDLE) begin
            if (rx_mark(rx_count_r, rx_reserve_r)) begin
              a_nxt.res.done_res  = 1'b1;
              a_nxt.res.exit_code = (rx_count_r >= RX_CW'(RX_DEPTH)) ? EXIT_OVERFLOW
                                                                    : EXIT_FULL;
            end else begin
              req_on    = 1'b1;
              phase_nxt = PH_XCHG;
              idle_v    = '0;
            end
          end
        end
        MODE_POLL: begin
          if (phase_r != PH_IDLE) begin
            // Transmit side: only during the exchange
            if (phase_r == PH_XCHG) begin
              if (flow_mode_r == FLOW_RTS)      can_send = in_data.cts;
              else if (flow_mode_r == FLOW_XON) can_send = send_allowed_r;
              else                              can_send = 1'b1;
              if (can_send && tx_count_r != '0) begin
                idle_v = '0;
                if (in_data.tx_ready) begin
                  tx_re                = 1'b1;
                  a_nxt.use_tx         = 1'b1;
                  a_nxt.res.tx_valid   = 1'b1;
                  tx_head_nxt  = (tx_head_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_r + 1'b1;
                  tx_count_nxt = tx_count_r - 1'b1;
                end
              end
            end
            // Receive side
            if (in_data.rx_valid) begin
              idle_v = '0;
              if (flow_mode_r == FLOW_XON &&
                  (in_data.rx_byte == XON_BYTE || in_data.rx_byte == XOFF_BYTE)) begin
                send_allowed_nxt = (in_data.rx_byte == XON_BYTE);
              end else begin
                if (rx_count_r < RX_CW'(RX_DEPTH)) begin
                  rx_we       = 1'b1;
                  rx_tail_nxt = (rx_tail_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_r + 1'b1;
                  rxc_v       = rx_count_r + 1'b1;
                end
                rx_count_nxt = rxc_v;
                if (phase_r == PH_XCHG) begin
                  if (rx_mark(rxc_v, rx_reserve_r)) begin
                    req_off   = 1'b1;
                    phase_nxt = PH_DRAIN;
                    idle_v    = '0;
                  end
                end else if (rxc_v >= RX_CW'(RX_DEPTH)) begin
                  a_nxt.res.done_res  = 1'b1;
                  a_nxt.res.exit_code = EXIT_OVERFLOW;
                  phase_nxt           = PH_IDLE;
                  idle_v              = '0;
                end
              end
            end else begin
              // Idle poll: count, saturating, and end the phase at the limit
              if (idle_v != IDLE_MAX) idle_v = idle_v + 16'd1;
              if (idle_v >= idle_limit_r) begin
                if (phase_r == PH_XCHG) begin
                  req_off   = 1'b1;
                  phase_nxt = PH_DRAIN;
                end else begin
                  a_nxt.res.done_res  = 1'b1;
                  a_nxt.res.exit_code = rx_mark(rx_count_r, rx_reserve_r) ? EXIT_FULL
                                                                          : EXIT_NO_ACT;
                  phase_nxt           = PH_IDLE;
                end
                idle_v = '0;
              end
            end
          end
        end
        MODE_PUSH: begin
          if (tx_count_r < TX_CW'(TX_DEPTH)) begin
            tx_we             = 1'b1;
            tx_tail_nxt  = (tx_tail_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_r + 1'b1;
            tx_count_nxt      = tx_count_r + 1'b1;
            a_nxt.res.push_ok = 1'b1;
          end
        end
        MODE_POP: begin
          if (rx_count_r != '0) begin
            rx_re        = 1'b1;
            a_nxt.use_rx = 1'b1;
            rx_head_nxt  = (rx_head_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
            rx_count_nxt = rx_count_r - 1'b1;
          end
        end
        MODE_PEEK: begin
          // Offset below the fill keeps the sum under twice the depth
          if (RX_PW'(rx_count_r) > RX_PW'(in_data.peek_offset)) begin
            rx_re        = 1'b1;
            a_nxt.use_rx = 1'b1;
            if (peek_sum >= (RX_PW+1)'(RX_DEPTH)) begin
              rx_raddr = RX_AW'(peek_sum - (RX_PW+1)'(RX_DEPTH));
            end else begin
              rx_raddr = RX_AW'(peek_sum);
            end
          end
        end
        default: begin
        end
      endcase

      // Raise or withdraw receiver readiness
      if (req_on) begin
        if (flow_mode_r == FLOW_RTS) begin
          rts_nxt = 1'b1;
        end else if (flow_mode_r == FLOW_XON && !announced_r) begin
          announced_nxt        = 1'b1;
          a_nxt.res.flow_valid = 1'b1;
          a_nxt.res.flow_byte  = XON_BYTE;
        end
      end
      if (req_off) begin
        if (flow_mode_r == FLOW_RTS) begin
          rts_nxt = 1'b0;
        end else if (flow_mode_r == FLOW_XON && announced_r) begin
          announced_nxt        = 1'b0;
          a_nxt.res.flow_valid = 1'b1;
          a_nxt.res.flow_byte  = XOFF_BYTE;
        end
      end

      a_nxt.res.rts     = rts_nxt;
      a_nxt.res.active  = (phase_nxt != PH_IDLE);
      a_nxt.res.rx_fill = RX_FILL_W'(rx_count_nxt);
      a_nxt.res.tx_fill = TX_FILL_W'(tx_count_nxt);
    end
    idle_count_nxt = idle_v;
  end

  // Merge queue read data into the result
  always_comb begin
    b_in = a_r.res;
    if (a_r.use_tx) b_in.tx_byte = tx_rdata;
    if (a_r.use_rx) b_in.read_byte = rx_rdata;
  end

  assign a_valid_nxt = in_fire || (a_valid_r && !b_load);
  assign b_valid_nxt = b_load || (b_valid_r && !out_ready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_mode_r    <= FLOW_NONE;
      rx_reserve_r   <= 8'd64;
      idle_limit_r   <= 16'd100;
      rx_head_r      <= '0;
      rx_tail_r      <= '0;
      rx_count_r     <= '0;
      tx_head_r      <= '0;
      tx_tail_r      <= '0;
      tx_count_r     <= '0;
      send_allowed_r <= 1'b1;
      announced_r    <= 1'b1;
      rts_r          <= 1'b0;
      phase_r        <= PH_IDLE;
      idle_count_r   <= '0;
      a_valid_r      <= 1'b0;
      b_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FLOW_MODE:  flow_mode_r  <= cfg_data[1:0];
          CFG_RX_RESERVE: rx_reserve_r <= cfg_data[7:0];
          CFG_IDLE_LIMIT: idle_limit_r <= cfg_data;
          default: begin
          end
        endcase
      end
      rx_head_r      <= rx_head_nxt;
      rx_tail_r      <= rx_tail_nxt;
      rx_count_r     <= rx_count_nxt;
      tx_head_r      <= tx_head_nxt;
      tx_tail_r      <= tx_tail_nxt;
      tx_count_r     <= tx_count_nxt;
      send_allowed_r <= send_allowed_nxt;
      announced_r    <= announced_nxt;
      rts_r          <= rts_nxt;
      phase_r        <= phase_nxt;
      idle_count_r   <= idle_count_nxt;
      a_valid_r      <= a_valid_nxt;
      b_valid_r      <= b_valid_nxt;
    end
  end

  // Result payload: advance only with its beat
  always_ff @(posedge clk) begin
    if (in_fire) a_r <= a_nxt;
    if (b_load)  b_r <= b_in;
  end

endmodule

// ===== sv/sfcb_checker.sv =====
// Port-level checks for the serial flow-control buffer, bound to the top level.
module sfcb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sfcb_pkg::sfcb_out_t out_data
);
  import sfcb_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Flow bytes are XON or XOFF, and zero when none is sent
  a_flow_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.flow_valid &&
                   (out_data.flow_byte == XON_BYTE || out_data.flow_byte == XOFF_BYTE)) ||
                  (!out_data.flow_valid && out_data.flow_byte == 8'd0))
    else $error("bad flow-control byte");

  // A finished phase leaves the block idle; no exit code without it
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.done_res && !out_data.active) ||
                  (!out_data.done_res && out_data.exit_code == EXIT_NO_ACT))
    else $error("exit report inconsistent with phase");

  // Fills never pass the queue depths
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rx_fill <= RX_FILL_W'(RX_DEPTH) &&
                  out_data.tx_fill <= TX_FILL_W'(TX_DEPTH))
    else $error("queue fill out of range");

  // A push never sends or reads in the same beat
  a_push_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.push_ok |-> !out_data.tx_valid && out_data.read_byte == 8'd0 &&
                                      !out_data.done_res)
    else $error("push result mixed with other events");

endmodule

bind serial_flow_control_buffer sfcb_checker u_sfcb_checker (.*);
